/* src/bps_pkg.sv */
// Shared types and constants of the bilinear pixel sampler.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package bps_pkg;

   // Default sizes of the image store and the coordinate format
   localparam int MAX_PIXELS_DEF    = 4096;
   localparam int FRACTION_BITS_DEF = 8;

   // Fixed field widths
   localparam int ADDR_IN_W   = 12;
   localparam int PIXEL_W     = 32;
   localparam int COORD_W     = 14;
   localparam int DIM_W       = 7;
   localparam int CHAN_W      = 8;
   localparam int NUM_CHAN    = PIXEL_W / CHAN_W;
   localparam int WEIGHT_BITS = 8;
   localparam int WT_W        = WEIGHT_BITS + 1;
   localparam int MAC_W       = CHAN_W + WT_W;
   localparam int ACC_W       = MAC_W + 1;
   localparam int NUM_TAPS    = 4;
   localparam int TAP_W       = 2;

   // Register reset values
   localparam logic [DIM_W-1:0] IMAGE_WIDTH_RST  = 7'd64;
   localparam logic [DIM_W-1:0] IMAGE_HEIGHT_RST = 7'd64;

   // Configuration register indexes
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;

   // Request actions
   localparam logic ACT_WRITE  = 1'b0;
   localparam logic ACT_SAMPLE = 1'b1;

   // Largest channel value
   localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hFF;

   // Sequencer states
   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_INDEX  = 6'b000010,
      ST_BOUND  = 6'b000100,
      ST_READ   = 6'b001000,
      ST_FINISH = 6'b010000,
      ST_EMIT   = 6'b100000
   } bps_state_type;

   // Control from the sequencer to the blend unit
   typedef struct packed {
      logic             load;   // take new weights, clear the sums
      logic             acc;    // add the tap pixel on the read port
      logic [TAP_W-1:0] tap;    // neighbor that the read data belongs to
   } bps_blend_ctl_type;

endpackage

`default_nettype wire

/* src/bps_pixel_mem.sv */
// Image store: one write port and one read port with registered read data.
// Depends on bps_pkg for the pixel width.
`timescale 1ns / 1ps
`default_nettype none

module bps_pixel_mem
   import bps_pkg::*;
#(
   parameter int DEPTH  = MAX_PIXELS_DEF,
   parameter int ADDR_W = $clog2(MAX_PIXELS_DEF)
) (
   input  wire logic               clock,
   input  wire logic               wr_en,
   input  wire logic [ADDR_W-1:0]  wr_addr,
   input  wire logic [PIXEL_W-1:0] wr_data,
   input  wire logic               rd_en,
   input  wire logic [ADDR_W-1:0]  rd_addr,
   output logic      [PIXEL_W-1:0] rd_data_ff
);

   logic [PIXEL_W-1:0] mem [DEPTH];

   // Store one pixel
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read one pixel, data valid the next cycle
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

/* src/bps_blend.sv */
// Bilinear weights and per-channel multiply-accumulate over four neighbors.
// Depends on bps_pkg for widths and the blend control struct.
`timescale 1ns / 1ps
`default_nettype none

module bps_blend
   import bps_pkg::*;
#(
   parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
   input  wire logic                     clock,
   input  wire bps_blend_ctl_type        ctl,
   input  wire logic [FRACTION_BITS-1:0] frac_x,
   input  wire logic [FRACTION_BITS-1:0] frac_y,
   input  wire logic [PIXEL_W-1:0]       tap_pixel,
   output logic      [PIXEL_W-1:0]       blend_pixel
);

   localparam int ONE_W  = FRACTION_BITS + 1;
   localparam int PROD_W = 2 * ONE_W;
   localparam int SHIFT  = 2 * FRACTION_BITS - WEIGHT_BITS;
   localparam int SUM_W  = ACC_W - WEIGHT_BITS;

   logic [ONE_W-1:0]  one_val;
   logic [ONE_W-1:0]  fx_val;
   logic [ONE_W-1:0]  fy_val;
   logic [ONE_W-1:0]  cfx_val;
   logic [ONE_W-1:0]  cfy_val;
   logic [PROD_W-1:0] prod   [NUM_TAPS];
   logic [WT_W-1:0]   weight_in [NUM_TAPS];
   logic [WT_W-1:0]   weight_ff [NUM_TAPS];
   logic [WT_W-1:0]   cur_weight;
   logic [MAC_W-1:0]  term   [NUM_CHAN];
   logic [ACC_W-1:0]  acc_ff [NUM_CHAN];
   logic [SUM_W-1:0]  sum_val [NUM_CHAN];

   // Fractions and complements, weights truncated to 8 fraction bits
   always_comb begin
      one_val = ONE_W'(1) << FRACTION_BITS;
      fx_val  = {1'b0, frac_x};
      fy_val  = {1'b0, frac_y};
      cfx_val = one_val - fx_val;
      cfy_val = one_val - fy_val;
      prod[0] = PROD_W'(cfx_val) * PROD_W'(cfy_val);
      prod[1] = PROD_W'(fx_val)  * PROD_W'(cfy_val);
      prod[2] = PROD_W'(cfx_val) * PROD_W'(fy_val);
      prod[3] = PROD_W'(fx_val)  * PROD_W'(fy_val);
      for (int t = 0; t < NUM_TAPS; t++) begin
         weight_in[t] = prod[t][SHIFT +: WT_W];
      end
   end

   // Weight of the neighbor now on the read port
   assign cur_weight = weight_ff[ctl.tap];

   always_comb begin
      for (int c = 0; c < NUM_CHAN; c++) begin
         term[c] = MAC_W'(tap_pixel[c*CHAN_W +: CHAN_W]) * MAC_W'(cur_weight);
      end
   end

   // Load weights and clear sums, or accumulate one neighbor
   always_ff @(posedge clock) begin
      if (ctl.load) begin
         for (int t = 0; t < NUM_TAPS; t++) begin
            weight_ff[t] <= weight_in[t];
         end
         for (int c = 0; c < NUM_CHAN; c++) begin
            acc_ff[c] <= '0;
         end
      end else if (ctl.acc) begin
         for (int c = 0; c < NUM_CHAN; c++) begin
            acc_ff[c] <= acc_ff[c] + ACC_W'(term[c]);
         end
      end
   end

   // Drop the weight fraction and clamp each channel
   always_comb begin
      for (int c = 0; c < NUM_CHAN; c++) begin
         sum_val[c] = acc_ff[c][ACC_W-1:WEIGHT_BITS];
         if (sum_val[c] > SUM_W'(CHAN_MAX)) begin
            blend_pixel[c*CHAN_W +: CHAN_W] = CHAN_MAX;
         end else begin
            blend_pixel[c*CHAN_W +: CHAN_W] = sum_val[c][CHAN_W-1:0];
         end
      end
   end

endmodule

`default_nettype wire

/* src/bilinear_pixel_sampler.sv */
// Top level of the bilinear pixel sampler: sequencer, registers, outputs.
// Depends on bps_pkg, bps_pixel_mem and bps_blend.
//
// A request is taken at a rising edge with start high and busy low.
// req_action selects a pixel write (req_pixel_address, req_pixel_value)
// or a sample at (req_coord_x, req_coord_y), unsigned fixed point with
// FRACTION_BITS fraction bits. A write gives no result and leaves busy low.
// A sample gives one result on rsp_sampled_pixel and rsp_out_of_range,
// held for exactly one cycle with rsp_valid high; the receiver cannot stall.
// An in-range sample runs through index and bounds setup (the weights load
// with the request), four reads of the single read port of the image store,
// a state for the last read data and one to settle the sums; rsp_valid is
// high once the sequencer is back in idle, when the next request may
// already be taken. A sample whose neighborhood leaves the image or the
// image store is answered after the bounds check with rsp_out_of_range high.
// Configuration writes on csr_ take effect at once and are meant for idle
// periods. Reset clears the sequencer and restores image_width and
// image_height to 64; the image store is not cleared and each pixel must
// be written before it is sampled.
`timescale 1ns / 1ps
`default_nettype none

module bilinear_pixel_sampler
   import bps_pkg::*;
#(
   parameter int MAX_PIXELS    = MAX_PIXELS_DEF,
   parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire logic                   req_action,
   input  wire logic [ADDR_IN_W-1:0]   req_pixel_address,
   input  wire logic [PIXEL_W-1:0]     req_pixel_value,
   input  wire logic [COORD_W-1:0]     req_coord_x,
   input  wire logic [COORD_W-1:0]     req_coord_y,
   output logic                        rsp_valid,
   output logic      [PIXEL_W-1:0]     rsp_sampled_pixel,
   output logic                        rsp_out_of_range,
   input  wire logic                   csr_write_enable,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [DIM_W-1:0]       csr_write_data
);

   localparam int ADDR_W = $clog2(MAX_PIXELS);
   localparam int POS_W  = COORD_W - FRACTION_BITS;
   localparam int IDX_W  = POS_W + DIM_W + 1;

   bps_state_type     state_ff, state_in;
   logic [DIM_W-1:0]  width_ff;
   logic [DIM_W-1:0]  height_ff;
   logic [POS_W-1:0]  px_ff;
   logic [POS_W-1:0]  py_ff;
   logic [IDX_W-1:0]  rowbase_ff;
   logic              xedge_ff;
   logic              yedge_ff;
   logic [ADDR_W-1:0] base_ff;
   logic [TAP_W-1:0]  rd_cnt_ff;
   logic [TAP_W-1:0]  rd_tap_ff;
   logic              rd_pending_ff;
   logic              rsp_valid_ff;
   logic [PIXEL_W-1:0] rsp_pixel_ff;
   logic              rsp_oor_ff;

   logic              accept;
   logic              accept_write;
   logic              accept_sample;
   logic [IDX_W-1:0]  base_idx;
   logic [IDX_W-1:0]  far_idx;
   logic              oob;
   logic              mem_wr_en;
   logic [ADDR_W-1:0] mem_wr_addr;
   logic              mem_rd_en;
   logic [ADDR_W-1:0] mem_rd_addr;
   logic [ADDR_W-1:0] stride;
   logic [PIXEL_W-1:0] mem_rd_data;
   logic [PIXEL_W-1:0] blend_pixel;
   bps_blend_ctl_type blend_ctl;

   // Request handshake
   assign busy          = (state_ff != ST_IDLE);
   assign accept        = start && !busy;
   assign accept_write  = accept && (req_action == ACT_WRITE);
   assign accept_sample = accept && (req_action == ACT_SAMPLE);

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= IMAGE_WIDTH_RST;
         height_ff <= IMAGE_HEIGHT_RST;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  width_ff  <= csr_write_data;
            CSR_IMAGE_HEIGHT: height_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (accept_sample) state_in = ST_INDEX;
         ST_INDEX:  state_in = ST_BOUND;
         ST_BOUND:  state_in = oob ? ST_IDLE : ST_READ;
         ST_READ:   if (rd_cnt_ff == TAP_W'(NUM_TAPS - 1)) state_in = ST_FINISH;
         ST_FINISH: state_in = ST_EMIT;
         ST_EMIT:   state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Neighborhood index and bounds
   assign base_idx = rowbase_ff + IDX_W'(px_ff);
   assign far_idx  = base_idx + IDX_W'(width_ff) + IDX_W'(1);
   assign oob      = xedge_ff || yedge_ff || (32'(far_idx) >= 32'(MAX_PIXELS));

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rd_cnt_ff     <= '0;
         rd_pending_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rd_pending_ff <= (state_ff == ST_READ);
         rsp_valid_ff  <= ((state_ff == ST_BOUND) && oob) || (state_ff == ST_EMIT);
         if (state_ff == ST_READ) begin
            rd_cnt_ff <= rd_cnt_ff + TAP_W'(1);
         end else begin
            rd_cnt_ff <= '0;
         end
      end
   end

   // Coordinate, index and result payload
   always_ff @(posedge clock) begin
      if (accept_sample) begin
         px_ff <= req_coord_x[COORD_W-1:FRACTION_BITS];
         py_ff <= req_coord_y[COORD_W-1:FRACTION_BITS];
      end
      if (state_ff == ST_INDEX) begin
         rowbase_ff <= IDX_W'(py_ff) * IDX_W'(width_ff);
         xedge_ff   <= (32'(px_ff) + 32'd1) >= 32'(width_ff);
         yedge_ff   <= (32'(py_ff) + 32'd1) >= 32'(height_ff);
      end
      if (state_ff == ST_BOUND) begin
         base_ff <= ADDR_W'(base_idx);
      end
      rd_tap_ff <= rd_cnt_ff;
      if ((state_ff == ST_BOUND) && oob) begin
         rsp_pixel_ff <= '0;
         rsp_oor_ff   <= 1'b1;
      end else if (state_ff == ST_EMIT) begin
         rsp_pixel_ff <= blend_pixel;
         rsp_oor_ff   <= 1'b0;
      end
   end

   // Store port: writes only from idle, reads only while sampling
   assign mem_wr_en   = accept_write && (32'(req_pixel_address) < 32'(MAX_PIXELS));
   assign mem_wr_addr = ADDR_W'(req_pixel_address);
   assign mem_rd_en   = (state_ff == ST_READ);
   assign stride      = ADDR_W'(width_ff);
   assign mem_rd_addr = base_ff + (rd_cnt_ff[0] ? ADDR_W'(1) : '0)
                                + (rd_cnt_ff[1] ? stride : '0);

   bps_pixel_mem #(
      .DEPTH  (MAX_PIXELS),
      .ADDR_W (ADDR_W)
   ) u_mem (
      .clock      (clock),
      .wr_en      (mem_wr_en),
      .wr_addr    (mem_wr_addr),
      .wr_data    (req_pixel_value),
      .rd_en      (mem_rd_en),
      .rd_addr    (mem_rd_addr),
      .rd_data_ff (mem_rd_data)
   );

   // Blend control: weights at request, accumulate as read data lands
   assign blend_ctl.load = accept_sample;
   assign blend_ctl.acc  = rd_pending_ff;
   assign blend_ctl.tap  = rd_tap_ff;

   bps_blend #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_blend (
      .clock       (clock),
      .ctl         (blend_ctl),
      .frac_x      (req_coord_x[FRACTION_BITS-1:0]),
      .frac_y      (req_coord_y[FRACTION_BITS-1:0]),
      .tap_pixel   (mem_rd_data),
      .blend_pixel (blend_pixel)
   );

   // Drive result ports
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_sampled_pixel = rsp_pixel_ff;
   assign rsp_out_of_range  = rsp_oor_ff;

   // A result always follows a cycle of sample work
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result strobe without preceding sample work");

   // A write request gives no result
   a_write_no_rsp: assert property (@(posedge clock) disable iff (reset)
      accept_write |=> !rsp_valid)
      else $error("write request produced a result");

   // A sample request starts the sequencer
   a_sample_busy: assert property (@(posedge clock) disable iff (reset)
      accept_sample |=> busy)
      else $error("sample request did not start the sequencer");

   // The store never reads and writes in the same cycle
   a_no_port_clash: assert property (@(posedge clock) disable iff (reset)
      !(mem_wr_en && mem_rd_en))
      else $error("image store read and write overlap");

endmodule

`default_nettype wire

/* verif/bilinear_sample_checker.sv */
// Checker of the bilinear pixel sampler: mirrors the image store and the
// size registers, predicts each sample and compares every result.
// Depends on bps_pkg.
`timescale 1ns / 1ps

module bilinear_sample_checker
   import bps_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic                   busy,
   input  logic                   req_action,
   input  logic [ADDR_IN_W-1:0]   req_pixel_address,
   input  logic [PIXEL_W-1:0]     req_pixel_value,
   input  logic [COORD_W-1:0]     req_coord_x,
   input  logic [COORD_W-1:0]     req_coord_y,
   input  logic                   rsp_valid,
   input  logic [PIXEL_W-1:0]     rsp_sampled_pixel,
   input  logic                   rsp_out_of_range,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [DIM_W-1:0]       csr_write_data,
   output int                     fail_count,
   output int                     pending_count
);

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel;
      logic               out_of_range;
   } sample_result_type;

   logic [PIXEL_W-1:0] pixel_image [MAX_PIXELS_DEF];
   int unsigned        img_width;
   int unsigned        img_height;
   sample_result_type  pending_samples [$];

   // Blend the 2x2 neighborhood at (x, y), or flag it when it leaves the image
   function automatic sample_result_type interpolate(input logic [COORD_W-1:0] x,
                                                     input logic [COORD_W-1:0] y);
      int unsigned        one, px, py, fx, fy, far, base, acc;
      int unsigned        wt [NUM_TAPS];
      logic [PIXEL_W-1:0] nb [NUM_TAPS];
      sample_result_type  res;
      one = 1 << FRACTION_BITS_DEF;
      px  = x >> FRACTION_BITS_DEF;
      py  = y >> FRACTION_BITS_DEF;
      fx  = x & (one - 1);
      fy  = y & (one - 1);
      res = '0;
      far = (py + 1) * img_width + px + 1;
      if (px + 1 >= img_width || py + 1 >= img_height || far >= MAX_PIXELS_DEF) begin
         res.out_of_range = 1'b1;
         return res;
      end
      base  = py * img_width + px;
      nb[0] = pixel_image[base];
      nb[1] = pixel_image[base + 1];
      nb[2] = pixel_image[base + img_width];
      nb[3] = pixel_image[base + img_width + 1];
      // weights are 8-bit fractions, truncated
      wt[0] = ((one - fx) * (one - fy)) >> (2 * FRACTION_BITS_DEF - WEIGHT_BITS);
      wt[1] = (fx * (one - fy)) >> (2 * FRACTION_BITS_DEF - WEIGHT_BITS);
      wt[2] = ((one - fx) * fy) >> (2 * FRACTION_BITS_DEF - WEIGHT_BITS);
      wt[3] = (fx * fy) >> (2 * FRACTION_BITS_DEF - WEIGHT_BITS);
      for (int c = 0; c < NUM_CHAN; c++) begin
         acc = 0;
         for (int k = 0; k < NUM_TAPS; k++)
            acc += nb[k][CHAN_W*c +: CHAN_W] * wt[k];
         acc = acc >> WEIGHT_BITS;
         if (acc > CHAN_MAX)
            acc = CHAN_MAX;
         res.pixel[CHAN_W*c +: CHAN_W] = acc[CHAN_W-1:0];
      end
      return res;
   endfunction

   // Count a failure, report only the first few
   task automatic record_failure(input string msg);
      fail_count++;
      if (fail_count <= 10)
         $display("%t: %s", $realtime, msg);
   endtask

   // Watch all three ports at each rising edge
   always @(posedge clock) begin : watch
      sample_result_type oldest;
      if (reset) begin
         img_width  = IMAGE_WIDTH_RST;
         img_height = IMAGE_HEIGHT_RST;
         pending_samples.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_IMAGE_WIDTH:  img_width  = csr_write_data;
               CSR_IMAGE_HEIGHT: img_height = csr_write_data;
               default: ;
            endcase
         end
         // compare a result against the oldest sample before taking a new request
         if (rsp_valid) begin
            if (pending_samples.size() == 0) begin
               record_failure($sformatf("result with no sample pending: pixel %h flag %b",
                                        rsp_sampled_pixel, rsp_out_of_range));
            end else begin
               oldest = pending_samples.pop_front();
               if (rsp_sampled_pixel !== oldest.pixel)
                  record_failure($sformatf("sampled_pixel mismatch: expected %h, got %h",
                                           oldest.pixel, rsp_sampled_pixel));
               if (rsp_out_of_range !== oldest.out_of_range)
                  record_failure($sformatf("out_of_range mismatch: expected %b, got %b",
                                           oldest.out_of_range, rsp_out_of_range));
            end
         end
         if (start && !busy) begin
            if (req_action == ACT_WRITE) begin
               if (req_pixel_address < MAX_PIXELS_DEF)
                  pixel_image[req_pixel_address] = req_pixel_value;
            end else begin
               pending_samples.push_back(interpolate(req_coord_x, req_coord_y));
            end
         end
      end
      pending_count = pending_samples.size();
   end

endmodule

/* verif/tb_bilinear_pixel_sampler.sv */
// Testbench top of the bilinear pixel sampler: clock, reset, requests and
// size register phases; depends on bps_pkg, the sampler and bilinear_sample_checker.
`timescale 1ns / 1ps

module tb_bilinear_pixel_sampler;
   import bps_pkg::*;

   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_B = 2'd3;
   localparam int NUM_PHASES      = 9;
   localparam int ITEMS_PER_PHASE = 210;
   localparam int SETTLE_CYCLES   = 12;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   start;
   logic                   busy;
   logic                   req_action;
   logic [ADDR_IN_W-1:0]   req_pixel_address;
   logic [PIXEL_W-1:0]     req_pixel_value;
   logic [COORD_W-1:0]     req_coord_x;
   logic [COORD_W-1:0]     req_coord_y;
   logic                   rsp_valid;
   logic [PIXEL_W-1:0]     rsp_sampled_pixel;
   logic                   rsp_out_of_range;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [DIM_W-1:0]       csr_write_data;
   int                     fail_count;
   int                     pending_count;

   // stimulus-side view of the image: which pixels hold data, current size
   bit                     pixel_written [MAX_PIXELS_DEF];
   int                     cfg_width;
   int                     cfg_height;
   bit                     idling_on;
   int                     items_sent;

   bilinear_pixel_sampler i_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_action        (req_action),
      .req_pixel_address (req_pixel_address),
      .req_pixel_value   (req_pixel_value),
      .req_coord_x       (req_coord_x),
      .req_coord_y       (req_coord_y),
      .rsp_valid         (rsp_valid),
      .rsp_sampled_pixel (rsp_sampled_pixel),
      .rsp_out_of_range  (rsp_out_of_range),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   bilinear_sample_checker i_checker (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_action        (req_action),
      .req_pixel_address (req_pixel_address),
      .req_pixel_value   (req_pixel_value),
      .req_coord_x       (req_coord_x),
      .req_coord_y       (req_coord_y),
      .rsp_valid         (rsp_valid),
      .rsp_sampled_pixel (rsp_sampled_pixel),
      .rsp_out_of_range  (rsp_out_of_range),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .fail_count        (fail_count),
      .pending_count     (pending_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Hold one request until it is taken; idle first now and then
   task automatic send_request(input logic action, input logic [ADDR_IN_W-1:0] addr,
                               input logic [PIXEL_W-1:0] value,
                               input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
      if (idling_on && $urandom_range(0, 4) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      start             <= 1'b1;
      req_action        <= action;
      req_pixel_address <= addr;
      req_pixel_value   <= value;
      req_coord_x       <= x;
      req_coord_y       <= y;
      @(posedge clock);
      while (busy) @(posedge clock);
      items_sent++;
   endtask

   function automatic logic [PIXEL_W-1:0] random_pixel();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         default: return $urandom;
      endcase
   endfunction

   task automatic store_pixel(input int addr, input logic [PIXEL_W-1:0] value);
      send_request(ACT_WRITE, ADDR_IN_W'(addr), value, COORD_W'($urandom),
                   COORD_W'($urandom));
      pixel_written[addr] = 1'b1;
   endtask

   // Sample at (x, y); fill any unwritten neighbor first
   task automatic sample_at(input int x, input int y);
      int px, py, far, base;
      int nbr [NUM_TAPS];
      px  = (x & 16'h3FFF) >> FRACTION_BITS_DEF;
      py  = (y & 16'h3FFF) >> FRACTION_BITS_DEF;
      far = (py + 1) * cfg_width + px + 1;
      if (px + 1 < cfg_width && py + 1 < cfg_height && far < MAX_PIXELS_DEF) begin
         base = py * cfg_width + px;
         nbr  = '{base, base + 1, base + cfg_width, base + cfg_width + 1};
         foreach (nbr[k])
            if (!pixel_written[nbr[k]])
               store_pixel(nbr[k], random_pixel());
      end
      send_request(ACT_SAMPLE, ADDR_IN_W'($urandom), $urandom, COORD_W'(x), COORD_W'(y));
   endtask

   // Drop start and wait until no sample is outstanding
   task automatic wait_for_drain();
      start <= 1'b0;
      do @(negedge clock); while (pending_count != 0 || busy);
      @(posedge clock);
   endtask

   // Write a size register once the block is idle
   task automatic set_register(input logic [CSR_INDEX_W-1:0] index,
                               input logic [DIM_W-1:0] data);
      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (index == CSR_IMAGE_WIDTH)
         cfg_width = data;
      else if (index == CSR_IMAGE_HEIGHT)
         cfg_height = data;
   endtask

   // One random request: mostly in-range samples, some edges, noise and writes
   task automatic random_item();
      int pick, pxmax, pymax, fx, fy;
      pick = $urandom_range(0, 99);
      fx   = ($urandom_range(0, 9) == 0) ? 255 : $urandom_range(0, 255);
      fy   = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(0, 255);
      pxmax = (cfg_width - 2 < 63) ? cfg_width - 2 : 63;
      pymax = (cfg_height - 2 < 63) ? cfg_height - 2 : 63;
      if (cfg_width > 0 && MAX_PIXELS_DEF / cfg_width - 2 < pymax)
         pymax = MAX_PIXELS_DEF / cfg_width - 2;
      if (pick < 15) begin
         store_pixel($urandom_range(0, MAX_PIXELS_DEF - 1), random_pixel());
      end else if (pick < 70 && pxmax >= 0 && pymax >= 0) begin
         sample_at(($urandom_range(0, pxmax) << FRACTION_BITS_DEF) | fx,
                   ($urandom_range(0, pymax) << FRACTION_BITS_DEF) | fy);
      end else if (pick < 85) begin
         // neighborhood right on the last column or row
         if ($urandom_range(0, 1))
            sample_at((((cfg_width > 0) ? cfg_width - 1 : 0) << FRACTION_BITS_DEF) | fx,
                      $urandom_range(0, 16383));
         else
            sample_at($urandom_range(0, 16383),
                      (((cfg_height > 0) ? cfg_height - 1 : 0) << FRACTION_BITS_DEF) | fy);
      end else begin
         sample_at($urandom_range(0, 16383), $urandom_range(0, 16383));
      end
   endtask

   initial begin : stimulus
      int phase_width  [NUM_PHASES];
      int phase_height [NUM_PHASES];
      int goal;
      bit drained;
      reset             <= 1'b1;
      start             <= 1'b0;
      req_action        <= ACT_WRITE;
      req_pixel_address <= '0;
      req_pixel_value   <= '0;
      req_coord_x       <= '0;
      req_coord_y       <= '0;
      csr_write_enable  <= 1'b0;
      csr_index         <= CSR_IMAGE_WIDTH;
      csr_write_data    <= '0;
      cfg_width   = IMAGE_WIDTH_RST;
      cfg_height  = IMAGE_HEIGHT_RST;
      idling_on   = 1'b1;
      items_sent  = 0;
      drained     = 1'b0;
      phase_width  = '{2, 64, 127, 0, 1, 2, 64, 13, 0};
      phase_height = '{2, 64, 127, 1, 0, 64, 2, 37, 0};
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: corner pixels, fraction extremes, edges of the image
      store_pixel(0, '0);
      store_pixel(1, '1);
      store_pixel(64, 32'h00FF_00FF);
      store_pixel(65, 32'hFF00_FF00);
      sample_at(0, 0);
      sample_at(16'h00FF, 0);
      sample_at(0, 16'h00FF);
      sample_at(16'h00FF, 16'h00FF);
      sample_at(16'h0080, 16'h0080);
      sample_at(16'h3FFF, 16'h3FFF);
      sample_at(63 << FRACTION_BITS_DEF, 0);
      sample_at(0, 63 << FRACTION_BITS_DEF);
      sample_at((62 << FRACTION_BITS_DEF) | 255, (62 << FRACTION_BITS_DEF) | 255);
      store_pixel(MAX_PIXELS_DEF - 1, $urandom);
      // writes to unused register indexes change nothing
      set_register(CSR_SPARE_A, 7'h7F);
      set_register(CSR_SPARE_B, 7'h01);
      sample_at(16'h0040, 16'h00C0);

      // random phases over several image sizes
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         if (phase == NUM_PHASES - 1) begin
            phase_width[phase]  = $urandom_range(2, 64);
            phase_height[phase] = $urandom_range(2, 64);
         end
         set_register(CSR_IMAGE_WIDTH, DIM_W'(phase_width[phase]));
         set_register(CSR_IMAGE_HEIGHT, DIM_W'(phase_height[phase]));
         idling_on = (phase != 4) && (phase != NUM_PHASES - 1);
         if (cfg_width == 127) begin
            // farthest neighbor just past the store, then just inside it
            sample_at(31 << FRACTION_BITS_DEF, 31 << FRACTION_BITS_DEF);
            sample_at((30 << FRACTION_BITS_DEF) | 16'h80, 31 << FRACTION_BITS_DEF);
         end
         goal = items_sent + ITEMS_PER_PHASE;
         while (items_sent < goal) begin
            if (phase == 2 && !drained && items_sent >= goal - ITEMS_PER_PHASE / 2) begin
               wait_for_drain();
               drained = 1'b1;
            end
            random_item();
         end
      end

      // drain and give the verdict
      wait_for_drain();
      repeat (20) @(posedge clock);
      if (fail_count == 0)
         $display("bilinear_pixel_sampler verification clean");
      else
         $display("bilinear_pixel_sampler verification failed");
      $finish;
   end

   initial begin : watchdog
      #10ms;
      $display("bilinear_pixel_sampler verification failed");
      $finish;
   end

endmodule

/* files.f */
src/bps_pkg.sv
src/bps_pixel_mem.sv
src/bps_blend.sv
src/bilinear_pixel_sampler.sv
verif/bilinear_sample_checker.sv
verif/tb_bilinear_pixel_sampler.sv
